// ===== rtl/tfn_pkg.sv =====
package tfn_pkg;

    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    // edges are brought below 2^30 before the cross product
    localparam int EDGE_BITS = 31;
    localparam int PROD_BITS = 2 * EDGE_BITS;
    // normalised cross components have their largest magnitude in [2^29, 2^30)
    localparam int NORM_MSB  = 29;
    localparam int MAG_BITS  = NORM_MSB + 1;
    localparam int SUM_BITS  = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;

    typedef logic [2:0][MAG_BITS-1:0] mag3_t;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } side_t;

endpackage

// ===== rtl/tfn_isqrt.sv =====
module tfn_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfn_pkg::side_t                   in_side,
    input  tfn_pkg::mag3_t                   in_mag,
    input  logic [tfn_pkg::SUM_BITS-1:0]     in_sum,
    output tfn_pkg::side_t                   out_side,
    output tfn_pkg::mag3_t                   out_mag,
    output logic [tfn_pkg::ROOT_BITS-1:0]    out_root
);

    localparam int STEPS = tfn_pkg::ROOT_BITS;
    localparam int RB    = tfn_pkg::ROOT_BITS;
    localparam int RW    = tfn_pkg::ROOT_BITS + 1;
    localparam int CW    = tfn_pkg::ROOT_BITS + 3;
    localparam int SB    = tfn_pkg::SUM_BITS;

    tfn_pkg::side_t side_reg [STEPS];
    tfn_pkg::mag3_t mag_reg  [STEPS];
    logic [SB-1:0]  sum_reg  [STEPS];
    logic [RW-1:0]  rem_reg  [STEPS];
    logic [RB-1:0]  root_reg [STEPS];

    // one result bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        tfn_pkg::side_t side_prev;
        tfn_pkg::mag3_t mag_prev;
        logic [SB-1:0]  sum_prev;
        logic [RW-1:0]  rem_prev;
        logic [RB-1:0]  root_prev;
        logic [CW-1:0]  cur;
        logic [CW-1:0]  trial;
        logic           ge;
        logic [RW-1:0]  rem_next;
        logic [RB-1:0]  root_next;

        if (k == 0) begin : g_first
            assign side_prev = in_side;
            assign mag_prev  = in_mag;
            assign sum_prev  = in_sum;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else begin : g_rest
            assign side_prev = side_reg[k-1];
            assign mag_prev  = mag_reg[k-1];
            assign sum_prev  = sum_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        always_comb
        begin
            cur       = {rem_prev, sum_prev[SB-1-2*k -: 2]};
            trial     = CW'({root_prev, 2'b01});
            ge        = (cur >= trial);
            rem_next  = ge ? RW'(cur - trial) : RW'(cur);
            root_next = {root_prev[RB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else
            begin
                side_reg[k] <= side_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            mag_reg[k]  <= mag_prev;
            sum_reg[k]  <= sum_prev;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign out_side = side_reg[STEPS-1];
    assign out_mag  = mag_reg[STEPS-1];
    assign out_root = root_reg[STEPS-1];

endmodule

// ===== rtl/tfn_div3.sv =====
module tfn_div3 #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tfn_pkg::side_t                      in_side,
    input  tfn_pkg::mag3_t                      in_mag,
    input  logic [tfn_pkg::ROOT_BITS-1:0]       in_root,
    output tfn_pkg::side_t                      out_side,
    output logic [2:0][NORMAL_FRAC_BITS:0]      out_quot
);

    localparam int F     = NORMAL_FRAC_BITS;
    localparam int STEPS = F + 1;
    localparam int NW    = tfn_pkg::MAG_BITS + F + 2;
    localparam int DW    = tfn_pkg::ROOT_BITS + 1;

    tfn_pkg::side_t          side_reg [STEPS+1];
    logic [2:0][NW-1:0]      rem_reg  [STEPS+1];
    logic [2:0][F:0]         q_reg    [STEPS+1];
    logic [DW-1:0]           d_reg    [STEPS+1];

    // entry stage: numerator m*2^(F+1) + r over 2r, which rounds half up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else
        begin
            side_reg[0] <= in_side;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            rem_reg[0][c] <= (NW'(in_mag[c]) << (F + 1)) + NW'(in_root);
        end
        q_reg[0] <= '0;
        d_reg[0] <= {in_root, 1'b0};
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < STEPS; j++) begin : g_bit
        logic [NW-1:0]      dsh;
        logic [2:0][NW-1:0] rem_next;
        logic [2:0][F:0]    q_next;

        always_comb
        begin
            dsh = NW'(d_reg[j]) << (F - j);
            for (int c = 0; c < 3; c++)
            begin
                if (rem_reg[j][c] >= dsh)
                begin
                    rem_next[c] = rem_reg[j][c] - dsh;
                    q_next[c]   = {q_reg[j][c][F-1:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = rem_reg[j][c];
                    q_next[c]   = {q_reg[j][c][F-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j+1] <= '0;
            end
            else
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= rem_next;
            q_reg[j+1]   <= q_next;
            d_reg[j+1]   <= d_reg[j];
        end
    end

    assign out_side = side_reg[STEPS];
    assign out_quot = q_reg[STEPS];

endmodule

// ===== rtl/triangle_face_normal.sv =====
// channel   direction  transfer on          payload
// command   in         start & !busy        first_*, second_*, third_* vertex coordinates
// result    out        done (one cycle)     normal_x/y/z, degenerate
//
// pipeline from start to done:
// nine stages of edge, cross product and normalisation, 31 square root stages,
// NORMAL_FRAC_BITS + 2 divider stages and the output register.
// a new triangle can be taken every cycle; busy is always low.
// reset clears only the valid, degenerate and sign flags; the receiver cannot stall done.
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       first_x,
    input  logic signed [COORD_BITS-1:0]       first_y,
    input  logic signed [COORD_BITS-1:0]       first_z,
    input  logic signed [COORD_BITS-1:0]       second_x,
    input  logic signed [COORD_BITS-1:0]       second_y,
    input  logic signed [COORD_BITS-1:0]       second_z,
    input  logic signed [COORD_BITS-1:0]       third_x,
    input  logic signed [COORD_BITS-1:0]       third_y,
    input  logic signed [COORD_BITS-1:0]       third_z,
    output logic                               done,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
    output logic                               degenerate
);

    localparam int F      = NORMAL_FRAC_BITS;
    localparam int OW     = F + 2;
    localparam int EW     = COORD_BITS + 1;
    localparam int SH_MAX = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
    localparam int ED     = tfn_pkg::EDGE_BITS;
    localparam int PB     = tfn_pkg::PROD_BITS;
    localparam int MB     = tfn_pkg::MAG_BITS;
    localparam int NM     = tfn_pkg::NORM_MSB;
    localparam int CB     = PB + 1;
    localparam int SB     = tfn_pkg::SUM_BITS;
    localparam int RB     = tfn_pkg::ROOT_BITS;

    assign busy = 1'b0;

    // stage 1: raw edges
    logic                 v1_reg;
    logic signed [EW-1:0] e_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg[0] <= EW'(first_x) - EW'(second_x);
        e_reg[1] <= EW'(first_y) - EW'(second_y);
        e_reg[2] <= EW'(first_z) - EW'(second_z);
        e_reg[3] <= EW'(third_x) - EW'(second_x);
        e_reg[4] <= EW'(third_y) - EW'(second_y);
        e_reg[5] <= EW'(third_z) - EW'(second_z);
    end

    // stage 2: common truncating shift so every edge stays below 2^30
    logic                 v2_reg;
    logic signed [ED-1:0] ed_reg  [6];
    logic signed [ED-1:0] ed_next [6];

    always_comb
    begin
        logic [EW-1:0] em [6];
        logic [EW-1:0] mor;
        logic [63:0]   t;
        int            sh;
        mor = '0;
        sh  = 0;
        for (int i = 0; i < 6; i++)
        begin
            em[i] = e_reg[i][EW-1] ? EW'(-e_reg[i]) : EW'(e_reg[i]);
            mor   = mor | em[i];
        end
        for (int k = 1; k <= SH_MAX; k++)
        begin
            if ((64'(mor) >> (NM + k)) != 64'd0)
            begin
                sh = k;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            t          = 64'(em[i]) >> sh;
            ed_next[i] = e_reg[i][EW-1] ? -ED'(t[MB-1:0]) : ED'(t[MB-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ed_reg <= ed_next;
    end

    // stage 3: the six partial products of the cross product
    logic                 v3_reg;
    logic signed [PB-1:0] pa_reg [3];
    logic signed [PB-1:0] pb_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg[0] <= PB'(ed_reg[1]) * PB'(ed_reg[5]);
        pb_reg[0] <= PB'(ed_reg[2]) * PB'(ed_reg[4]);
        pa_reg[1] <= PB'(ed_reg[2]) * PB'(ed_reg[3]);
        pb_reg[1] <= PB'(ed_reg[0]) * PB'(ed_reg[5]);
        pa_reg[2] <= PB'(ed_reg[0]) * PB'(ed_reg[4]);
        pb_reg[2] <= PB'(ed_reg[1]) * PB'(ed_reg[3]);
    end

    // stage 4: cross components as sign and magnitude
    tfn_pkg::side_t s4_reg;
    tfn_pkg::side_t s4_next;
    logic [PB-1:0]  cm4_reg  [3];
    logic [PB-1:0]  cm4_next [3];

    always_comb
    begin
        logic signed [CB-1:0] c;
        s4_next       = '0;
        s4_next.valid = v3_reg;
        for (int i = 0; i < 3; i++)
        begin
            c              = CB'(pa_reg[i]) - CB'(pb_reg[i]);
            s4_next.neg[i] = c[CB-1];
            cm4_next[i]    = c[CB-1] ? PB'(-c) : PB'(c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
        end
        else
        begin
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cm4_reg <= cm4_next;
    end

    // stage 5: or of the magnitudes has the same leading one as their maximum
    tfn_pkg::side_t s5_reg;
    logic [PB-1:0]  cm5_reg [3];
    logic [PB-1:0]  or5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_reg <= '0;
        end
        else
        begin
            s5_reg <= s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cm5_reg <= cm4_reg;
        or5_reg <= cm4_reg[0] | cm4_reg[1] | cm4_reg[2];
    end

    // stage 6: leading one position, zero test
    localparam int PW = $clog2(PB);

    tfn_pkg::side_t s6_reg;
    tfn_pkg::side_t s6_next;
    logic [PB-1:0]  cm6_reg [3];
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  pos_next;

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < PB; i++)
        begin
            if (or5_reg[i])
            begin
                pos_next = PW'(i);
            end
        end
        s6_next       = s5_reg;
        s6_next.degen = (or5_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_reg <= '0;
        end
        else
        begin
            s6_reg <= s6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cm6_reg <= cm5_reg;
        pos_reg <= pos_next;
    end

    // stage 7: block normalisation to a leading one at bit 29
    tfn_pkg::side_t s7_reg;
    tfn_pkg::mag3_t nm7_reg;
    tfn_pkg::mag3_t nm7_next;

    always_comb
    begin
        logic [PB-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg >= PW'(NM))
            begin
                t = cm6_reg[i] >> (pos_reg - PW'(NM));
            end
            else
            begin
                t = cm6_reg[i] << (PW'(NM) - pos_reg);
            end
            nm7_next[i] = t[MB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_reg <= '0;
        end
        else
        begin
            s7_reg <= s6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm7_reg <= nm7_next;
    end

    // stage 8: squares
    tfn_pkg::side_t s8_reg;
    tfn_pkg::mag3_t nm8_reg;
    logic [2*MB-1:0] sq8_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_reg <= '0;
        end
        else
        begin
            s8_reg <= s7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm8_reg <= nm7_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq8_reg[i] <= (2*MB)'(nm7_reg[i]) * (2*MB)'(nm7_reg[i]);
        end
    end

    // stage 9: squared length
    tfn_pkg::side_t s9_reg;
    tfn_pkg::mag3_t nm9_reg;
    logic [SB-1:0]  sum9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_reg <= '0;
        end
        else
        begin
            s9_reg <= s8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm9_reg  <= nm8_reg;
        sum9_reg <= SB'(sq8_reg[0]) + SB'(sq8_reg[1]) + SB'(sq8_reg[2]);
    end

    // length and per-component division
    tfn_pkg::side_t  sq_side;
    tfn_pkg::mag3_t  sq_mag;
    logic [RB-1:0]   sq_root;
    tfn_pkg::side_t  dv_side;
    logic [2:0][F:0] dv_quot;

    tfn_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (s9_reg),
        .in_mag   (nm9_reg),
        .in_sum   (sum9_reg),
        .out_side (sq_side),
        .out_mag  (sq_mag),
        .out_root (sq_root)
    );

    tfn_div3 #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (sq_side),
        .in_mag   (sq_mag),
        .in_root  (sq_root),
        .out_side (dv_side),
        .out_quot (dv_quot)
    );

    // output register: clamp, sign, zero for a degenerate triangle
    logic                 done_reg;
    logic                 degen_reg;
    logic signed [OW-1:0] n_reg  [3];
    logic signed [OW-1:0] n_next [3];

    always_comb
    begin
        logic [F:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_quot[i] > (F+1)'(1) << F) ? ((F+1)'(1) << F) : dv_quot[i];
            if (dv_side.degen)
            begin
                n_next[i] = '0;
            end
            else
            begin
                n_next[i] = dv_side.neg[i] ? -OW'(qc) : OW'(qc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degen_reg <= dv_side.degen;
        n_reg     <= n_next;
    end

    assign done       = done_reg;
    assign degenerate = degen_reg;
    assign normal_x   = n_reg[0];
    assign normal_y   = n_reg[1];
    assign normal_z   = n_reg[2];

endmodule
